[src/ptnr_pkg.sv]
// shared types and constants for the too-near repulsion unit
// no dependencies
package ptnr_pkg;

  localparam int FRAC_BITS = 16;
  localparam int ACC_W     = 48;
  localparam int QUO_W     = 33;
  localparam logic [5:0] DIV_LAST = 6'(QUO_W - 1);

  // configuration register indexes
  localparam logic [1:0] REG_DENSITY     = 2'd0;
  localparam logic [1:0] REG_NEAR_LIMIT  = 2'd1;
  localparam logic [1:0] REG_RESTITUTION = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_NLSQ, ST_AXX, ST_AZZ, ST_HXD, ST_HZD, ST_DOTS, ST_CHK,
    ST_NLO, ST_NHI, ST_NADD, ST_DINIT, ST_DIV, ST_TERM, ST_ACC, ST_FIN
  } state_e;

  typedef enum logic [2:0] {
    MS_NL, MS_AXX, MS_AZZ, MS_HXD, MS_HZD, MS_NLO, MS_NHI, MS_TERM
  } mul_sel_e;

  typedef enum logic [3:0] {
    DS_NONE, DS_NLSQ, DS_R2, DS_R2ADD, DS_DOT, DS_DOTADD, DS_NUMLO, DS_NUMHI, DS_ACC
  } dst_sel_e;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_e mul_sel;
    dst_sel_e dst;
    logic     div_init;
    logic     div_step;
    logic     axis_set;
    logic     emit;
  } ptnr_cmd_t;

  typedef struct packed {
    logic go;
    logic div_done;
    logic axis;
    logic last;
    logic out_busy;
  } ptnr_stat_t;

endpackage

[src/ptnr_ctrl.sv]
// sequencer for the too-near repulsion unit
// depends on ptnr_pkg
module ptnr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ptnr_pkg::ptnr_stat_t stat_i,
  output ptnr_pkg::ptnr_cmd_t  cmd_o
);
  import ptnr_pkg::*;

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_NLSQ;
      ST_NLSQ:  state_d = ST_AXX;
      ST_AXX:   state_d = ST_AZZ;
      ST_AZZ:   state_d = ST_HXD;
      ST_HXD:   state_d = ST_HZD;
      ST_HZD:   state_d = ST_DOTS;
      ST_DOTS:  state_d = ST_CHK;
      ST_CHK:   state_d = stat_i.go ? ST_NLO : ST_FIN;
      ST_NLO:   state_d = ST_NHI;
      ST_NHI:   state_d = ST_NADD;
      ST_NADD:  state_d = ST_DINIT;
      ST_DINIT: state_d = ST_DIV;
      ST_DIV:   if (stat_i.div_done) state_d = ST_TERM;
      ST_TERM:  state_d = ST_ACC;
      ST_ACC:   state_d = stat_i.axis ? ST_FIN : ST_NLO;
      ST_FIN: begin
        if (!stat_i.last || !stat_i.out_busy) state_d = ST_IDLE;
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o          = '0;
    cmd_o.mul_sel  = MS_NL;
    cmd_o.dst      = DS_NONE;
    in_stall_o     = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE:  cmd_o.load = in_valid_i;
      ST_NLSQ: begin
        cmd_o.mul_en = 1'b1; cmd_o.mul_sel = MS_NL;
      end
      ST_AXX: begin
        cmd_o.mul_en = 1'b1; cmd_o.mul_sel = MS_AXX; cmd_o.dst = DS_NLSQ;
      end
      ST_AZZ: begin
        cmd_o.mul_en = 1'b1; cmd_o.mul_sel = MS_AZZ; cmd_o.dst = DS_R2;
      end
      ST_HXD: begin
        cmd_o.mul_en = 1'b1; cmd_o.mul_sel = MS_HXD; cmd_o.dst = DS_R2ADD;
      end
      ST_HZD: begin
        cmd_o.mul_en = 1'b1; cmd_o.mul_sel = MS_HZD; cmd_o.dst = DS_DOT;
      end
      ST_DOTS:  cmd_o.dst = DS_DOTADD;
      ST_CHK:   ;
      ST_NLO: begin
        cmd_o.mul_en = 1'b1; cmd_o.mul_sel = MS_NLO;
      end
      ST_NHI: begin
        cmd_o.mul_en = 1'b1; cmd_o.mul_sel = MS_NHI; cmd_o.dst = DS_NUMLO;
      end
      ST_NADD:  cmd_o.dst = DS_NUMHI;
      ST_DINIT: cmd_o.div_init = 1'b1;
      ST_DIV:   cmd_o.div_step = 1'b1;
      ST_TERM: begin
        cmd_o.mul_en = 1'b1; cmd_o.mul_sel = MS_TERM;
      end
      ST_ACC: begin
        cmd_o.dst = DS_ACC; cmd_o.axis_set = !stat_i.axis;
      end
      ST_FIN:   cmd_o.emit = stat_i.last && !stat_i.out_busy;
      default:  ;
    endcase
  end

endmodule

[src/ptnr_dp.sv]
// datapath: config registers, shared multiplier, restoring divider, sums, result register
// depends on ptnr_pkg
module ptnr_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [30:0]          cfg_data_i,
  input  logic signed [31:0]   self_px_i,
  input  logic signed [31:0]   self_pz_i,
  input  logic signed [31:0]   self_vx_i,
  input  logic signed [31:0]   self_vz_i,
  input  logic signed [31:0]   nb_px_i,
  input  logic signed [31:0]   nb_pz_i,
  input  logic signed [31:0]   nb_vx_i,
  input  logic signed [31:0]   nb_vz_i,
  input  logic                 last_neighbor_i,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output logic signed [31:0]   corr_vx_o,
  output logic signed [31:0]   corr_vz_o,
  output logic                 saturated_o,
  input  ptnr_pkg::ptnr_cmd_t  cmd_i,
  output ptnr_pkg::ptnr_stat_t stat_o
);
  import ptnr_pkg::*;

  localparam logic signed [49:0] ACC_HI = 50'sd140737488355327;
  localparam logic signed [49:0] ACC_LO = -50'sd140737488355328;
  localparam logic signed [ACC_W-1:0] OUT_HI = 48'sd2147483647;
  localparam logic signed [ACC_W-1:0] OUT_LO = -48'sd2147483648;

  logic [30:0] density_q, near_limit_q;
  logic [17:0] restitution_q;

  logic signed [32:0] dx_q, dz_q, hx_q, hz_q;
  logic [32:0]        ax_q, az_q;
  logic               last_q, axis_q;
  logic signed [67:0] p_q;
  logic [61:0]        nlsq_q;
  logic [65:0]        r2_q;
  logic signed [65:0] dot_q;
  logic [93:0]        num_q;
  logic [61:0]        rem_q;
  logic [32:0]        nsh_q;
  logic [QUO_W-1:0]   q_q;
  logic [5:0]         cnt_q;
  logic signed [ACC_W-1:0] sum_x_q, sum_z_q;
  logic               out_valid_q, sat_q;
  logic signed [31:0] corr_vx_q, corr_vz_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      density_q     <= 31'd65536;
      near_limit_q  <= 31'd0;
      restitution_q <= 18'd65536;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DENSITY:     density_q     <= cfg_data_i;
        REG_NEAR_LIMIT:  near_limit_q  <= cfg_data_i;
        REG_RESTITUTION: restitution_q <= cfg_data_i[17:0];
        default: ;
      endcase
    end
  end

  // offsets and half velocity differences at request accept
  logic signed [32:0] dx_w, dz_w, dvx_w, dvz_w;
  assign dx_w  = 33'(nb_px_i) - 33'(self_px_i);
  assign dz_w  = 33'(nb_pz_i) - 33'(self_pz_i);
  assign dvx_w = 33'(self_vx_i) - 33'(nb_vx_i);
  assign dvz_w = 33'(self_vz_i) - 33'(nb_vz_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      dx_q   <= dx_w;
      dz_q   <= dz_w;
      ax_q   <= dx_w[32] ? 33'(-dx_w) : 33'(dx_w);
      az_q   <= dz_w[32] ? 33'(-dz_w) : 33'(dz_w);
      // halve, rounding toward zero
      hx_q   <= $signed(dvx_w + 33'(dvx_w[32])) >>> 1;
      hz_q   <= $signed(dvz_w + 33'(dvz_w[32])) >>> 1;
      last_q <= last_neighbor_i;
    end
  end

  // shared multiplier with registered product
  logic [32:0]        ad_w;
  logic signed [33:0] mul_a, mul_b;
  assign ad_w = axis_q ? az_q : ax_q;

  always_comb begin
    case (cmd_i.mul_sel)
      MS_NL:   begin mul_a = {3'b0, near_limit_q}; mul_b = {3'b0, near_limit_q}; end
      MS_AXX:  begin mul_a = {1'b0, ax_q};         mul_b = {1'b0, ax_q};         end
      MS_AZZ:  begin mul_a = {1'b0, az_q};         mul_b = {1'b0, az_q};         end
      MS_HXD:  begin mul_a = 34'(hx_q);            mul_b = 34'(dx_q);            end
      MS_HZD:  begin mul_a = 34'(hz_q);            mul_b = 34'(dz_q);            end
      MS_NLO:  begin mul_a = {2'b0, dot_q[31:0]};  mul_b = {1'b0, ad_w};         end
      MS_NHI:  begin mul_a = {3'b0, dot_q[62:32]}; mul_b = {1'b0, ad_w};         end
      MS_TERM: begin mul_a = {16'b0, restitution_q}; mul_b = {1'b0, q_q};        end
      default: begin mul_a = '0;                   mul_b = '0;                   end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) p_q <= 68'(mul_a) * 68'(mul_b);
  end

  // product destinations
  always_ff @(posedge clk_i) begin
    case (cmd_i.dst)
      DS_NLSQ:   nlsq_q <= p_q[61:0];
      DS_R2:     r2_q   <= p_q[65:0];
      DS_R2ADD:  r2_q   <= r2_q + p_q[65:0];
      DS_DOT:    dot_q  <= p_q[65:0];
      DS_DOTADD: dot_q  <= dot_q + p_q[65:0];
      DS_NUMLO:  num_q  <= {31'b0, p_q[62:0]};
      DS_NUMHI:  num_q  <= num_q + {p_q[61:0], 32'b0};
      default: ;
    endcase
  end

  // restoring divider, one quotient bit a cycle
  logic [62:0] rem_sh;
  logic        rem_ge;
  assign rem_sh = {rem_q, nsh_q[32]};
  assign rem_ge = rem_sh >= {1'b0, r2_q[61:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.div_init) begin
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q + 6'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      rem_q <= {1'b0, num_q[93:33]};
      nsh_q <= num_q[32:0];
      q_q   <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_ge ? 62'(rem_sh - {1'b0, r2_q[61:0]}) : rem_sh[61:0];
      nsh_q <= {nsh_q[31:0], 1'b0};
      q_q   <= {q_q[QUO_W-2:0], rem_ge};
    end
  end

  // saturating accumulate of the scaled term
  logic [67:0]             term_full;
  logic [35:0]             term_w;
  logic signed [ACC_W-1:0] acc_cur;
  logic signed [49:0]      acc_n;
  logic signed [ACC_W-1:0] acc_sat;
  logic                    d_neg;
  assign term_full = p_q >> FRAC_BITS;
  assign term_w    = term_full[35:0];
  assign acc_cur   = axis_q ? sum_z_q : sum_x_q;
  assign d_neg     = axis_q ? dz_q[32] : dx_q[32];
  assign acc_n     = d_neg ? 50'(acc_cur) + $signed({14'b0, term_w})
                           : 50'(acc_cur) - $signed({14'b0, term_w});
  always_comb begin
    if (acc_n > ACC_HI)      acc_sat = ACC_HI[ACC_W-1:0];
    else if (acc_n < ACC_LO) acc_sat = ACC_LO[ACC_W-1:0];
    else                     acc_sat = acc_n[ACC_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_x_q <= '0;
      sum_z_q <= '0;
      axis_q  <= 1'b0;
    end else begin
      if (cmd_i.load) axis_q <= 1'b0;
      else if (cmd_i.axis_set) axis_q <= 1'b1;
      if (cmd_i.emit) begin
        sum_x_q <= '0;
        sum_z_q <= '0;
      end else if (cmd_i.dst == DS_ACC) begin
        if (axis_q) sum_z_q <= acc_sat;
        else        sum_x_q <= acc_sat;
      end
    end
  end

  // output clip and result register
  logic sat_x, sat_z;
  assign sat_x = (sum_x_q > OUT_HI) || (sum_x_q < OUT_LO);
  assign sat_z = (sum_z_q > OUT_HI) || (sum_z_q < OUT_LO);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      corr_vx_q <= (sum_x_q > OUT_HI) ? 32'sh7FFFFFFF :
                   (sum_x_q < OUT_LO) ? 32'sh80000000 : sum_x_q[31:0];
      corr_vz_q <= (sum_z_q > OUT_HI) ? 32'sh7FFFFFFF :
                   (sum_z_q < OUT_LO) ? 32'sh80000000 : sum_z_q[31:0];
      sat_q     <= sat_x || sat_z;
    end
  end

  assign out_valid_o = out_valid_q;
  assign corr_vx_o   = corr_vx_q;
  assign corr_vz_o   = corr_vz_q;
  assign saturated_o = sat_q;

  // status to the sequencer
  assign stat_o.go = (density_q != '0) && (ax_q < {2'b0, near_limit_q})
                     && (az_q < {2'b0, near_limit_q}) && (r2_q != '0)
                     && (r2_q < {4'b0, nlsq_q}) && (dot_q > 66'sd0);
  assign stat_o.div_done = (cnt_q == DIV_LAST);
  assign stat_o.axis     = axis_q;
  assign stat_o.last     = last_q;
  assign stat_o.out_busy = out_valid_q && out_stall_i;

  // checks
  a_div_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> cnt_q <= DIV_LAST)
    else $error("divider stepped past its last quotient bit");
  a_quo_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mul_en && cmd_i.mul_sel == MS_TERM |-> !q_q[QUO_W-1])
    else $error("quotient exceeds half velocity bound");
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> !(out_valid_q && out_stall_i))
    else $error("result overwritten while held");
  a_emit_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> sum_x_q == '0 && sum_z_q == '0 && out_valid_q)
    else $error("sums not cleared on emit");

endmodule

[src/particle_too_near_repulsion_unit.sv]
// too-near repulsion unit: one neighbor request at a time; a pair outside the near limit
// or separating skips the correction, otherwise the correction is applied
// (two divisions on the shared restoring divider, plus multiplier steps)
// result is registered and can wait while the next request is taken
// async active-low reset clears sums, sequencer, output valid and loads register defaults
// depends on ptnr_pkg, ptnr_ctrl, ptnr_dp
module particle_too_near_repulsion_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [30:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] self_px_i,
  input  logic signed [31:0] self_pz_i,
  input  logic signed [31:0] self_vx_i,
  input  logic signed [31:0] self_vz_i,
  input  logic signed [31:0] nb_px_i,
  input  logic signed [31:0] nb_pz_i,
  input  logic signed [31:0] nb_vx_i,
  input  logic signed [31:0] nb_vz_i,
  input  logic               last_neighbor_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] corr_vx_o,
  output logic signed [31:0] corr_vz_o,
  output logic               saturated_o
);
  import ptnr_pkg::*;

  ptnr_cmd_t  cmd;
  ptnr_stat_t stat;

  // sequencer
  ptnr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // arithmetic and storage
  ptnr_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .self_px_i       (self_px_i),
    .self_pz_i       (self_pz_i),
    .self_vx_i       (self_vx_i),
    .self_vz_i       (self_vz_i),
    .nb_px_i         (nb_px_i),
    .nb_pz_i         (nb_pz_i),
    .nb_vx_i         (nb_vx_i),
    .nb_vz_i         (nb_vz_i),
    .last_neighbor_i (last_neighbor_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .corr_vx_o       (corr_vx_o),
    .corr_vz_o       (corr_vz_o),
    .saturated_o     (saturated_o),
    .cmd_i           (cmd),
    .stat_o          (stat)
  );

endmodule
